FILE: rtl/rgb_to_hls_converter_assert.svh
// Assertion macros for the RGB to HLS converter
`ifndef RGB_TO_HLS_CONVERTER_ASSERT_SVH
`define RGB_TO_HLS_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/rhc_pkg.sv
// Shared constants and types for the RGB to HLS converter
`default_nettype none
package rhc_pkg;
    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 6;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;
endpackage
`default_nettype wire

FILE: rtl/rhc_front.sv
// Front stages: channel max/min, sector pick and division operands
`default_nettype none
module rhc_front #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6,
    parameter int QUO_BITS          = 13
) (
    input  wire logic                                  aclk,
    input  wire logic                                  en,
    input  wire logic [CHANNEL_BITS-1:0]               red,
    input  wire logic [CHANNEL_BITS-1:0]               green,
    input  wire logic [CHANNEL_BITS-1:0]               blue,
    output logic [QUO_BITS+CHANNEL_BITS:0]             hue_num,
    output logic [CHANNEL_BITS:0]                      hue_den,
    output logic [QUO_BITS+CHANNEL_BITS:0]             sat_num,
    output logic [CHANNEL_BITS:0]                      sat_den,
    output rhc_pkg::sector_t                           sector,
    output logic [CHANNEL_BITS-1:0]                    light,
    output logic                                       achrom
);
    import rhc_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int NW = QUO_BITS + CHANNEL_BITS + 1;
    localparam logic [NW-1:0] HUE_MUL  = NW'(120 << HUE_FRACTION_BITS);
    localparam logic [NW-1:0] FULL_NW  = NW'((1 << CB) - 1);
    localparam logic [CB:0]   FULL     = {1'b0, {CB{1'b1}}};
    localparam logic [CB:0]   TWO_FULL = {{CB{1'b1}}, 1'b0};

    // stage A
    logic [CB-1:0] mx_next, mn_next, pos_next, neg_next;
    sector_t       sec_next;
    logic [CB-1:0] mx_reg, mn_reg, pos_reg, neg_reg;
    sector_t       sec_reg;

    always_comb begin
        mx_next = red;
        if (green > mx_next) mx_next = green;
        if (blue > mx_next) mx_next = blue;
        mn_next = red;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next) mn_next = blue;
        if (red >= green && red >= blue) begin
            sec_next = SEC_RED;
            pos_next = green;
            neg_next = blue;
        end else if (green >= blue) begin
            sec_next = SEC_GREEN;
            pos_next = blue;
            neg_next = red;
        end else begin
            sec_next = SEC_BLUE;
            pos_next = red;
            neg_next = green;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg  <= mx_next;
            mn_reg  <= mn_next;
            pos_reg <= pos_next;
            neg_reg <= neg_next;
            sec_reg <= sec_next;
        end
    end

    // stage B
    logic [CB-1:0] d;
    logic [CB:0]   s, s_inc, den_w, tp;
    logic [CB-1:0] den;

    always_comb begin
        d     = mx_reg - mn_reg;
        s     = {1'b0, mx_reg} + {1'b0, mn_reg};
        s_inc = s + {{CB{1'b0}}, 1'b1};
        den_w = (s <= FULL) ? s : (TWO_FULL - s);
        den   = den_w[CB-1:0];
        tp    = {1'b0, pos_reg} + {1'b0, d} - {1'b0, neg_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_num <= NW'(tp) * HUE_MUL + NW'(d);
            hue_den <= {d, 1'b0};
            sat_num <= ((NW'(d) * FULL_NW) << 1) + NW'(den);
            sat_den <= {den, 1'b0};
            sector  <= sec_reg;
            light   <= s_inc[CB:1];
            achrom  <= (d == '0);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rhc_div.sv
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module rhc_div #(
    parameter int DEN_W = 9,
    parameter int QUO_W = 13
) (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [QUO_W+DEN_W-1:0] num,
    input  wire logic [DEN_W-1:0]       den,
    output logic [QUO_W-1:0]            quo
);
    logic [DEN_W-1:0] rem_reg [QUO_W-1];
    logic [QUO_W-1:0] lo_reg  [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [DEN_W-1:0] rem_in, den_in, rem_next;
        logic [QUO_W-1:0] lo_in, q_in, q_next;
        logic [DEN_W:0]   trial, diff;
        logic             ge;

        if (i == 0) begin : g_first
            assign rem_in = num[QUO_W+DEN_W-1:QUO_W];
            assign lo_in  = num[QUO_W-1:0];
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = quo_reg[i-1];
        end

        always_comb begin
            trial    = {rem_in, lo_in[QUO_W-1]};
            diff     = trial - {1'b0, den_in};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next   = {q_in[QUO_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) quo_reg[i] <= q_next;
        end

        if (i < QUO_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    lo_reg[i]  <= {lo_in[QUO_W-2:0], 1'b0};
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];
endmodule
`default_nettype wire

FILE: rtl/rhc_back.sv
// Output stage: hue sector offset, wrap and result register
`default_nettype none
module rhc_back #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6,
    parameter int QUO_BITS          = 13,
    parameter int HUE_BITS          = 15
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire rhc_pkg::sector_t        sector,
    input  wire logic [QUO_BITS-1:0]     hue_q,
    input  wire logic [QUO_BITS-1:0]     sat_q,
    input  wire logic [CHANNEL_BITS-1:0] light_in,
    input  wire logic                    achrom_in,
    output logic                         out_valid,
    output logic [HUE_BITS-1:0]          hue,
    output logic [CHANNEL_BITS-1:0]      light,
    output logic [CHANNEL_BITS-1:0]      sat,
    output logic                         achrom
);
    import rhc_pkg::*;

    localparam int HW1 = HUE_BITS + 1;
    localparam logic [HW1-1:0] SIXTY = HW1'(60 << HUE_FRACTION_BITS);
    localparam logic [HW1-1:0] TURN  = HW1'(360 << HUE_FRACTION_BITS);

    logic [HW1-1:0]          base, sum, wrapped;
    logic [HUE_BITS-1:0]     hue_next;
    logic [CHANNEL_BITS-1:0] sat_next;

    // quotient carries a +60 degree bias, so sectors start at 300, 420, 540
    always_comb begin
        case (sector)
            SEC_RED:   base = SIXTY * HW1'(5);
            SEC_GREEN: base = SIXTY * HW1'(7);
            SEC_BLUE:  base = SIXTY * HW1'(9);
            default:   base = '0;
        endcase
        sum      = base + HW1'(hue_q);
        wrapped  = (sum >= TURN) ? (sum - TURN) : sum;
        hue_next = achrom_in ? '0 : wrapped[HUE_BITS-1:0];
        sat_next = achrom_in ? '0 : sat_q[CHANNEL_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue    <= hue_next;
            light  <= light_in;
            sat    <= sat_next;
            achrom <= achrom_in;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rgb_to_hls_converter.sv
// RGB to HLS converter, top level
// Input stream: one RGB pixel per transaction on s_tdata (red, green, blue
// from the lowest bit up). Output stream: hue, lightness, saturation on
// m_tdata, achromatic flag on m_tuser.
// Hue is in 1/2^HUE_FRACTION_BITS degree, 0 to below 360 degrees; lightness
// and saturation are rounded to the channel scale. A gray pixel gives hue 0,
// saturation 0 and achromatic high.
// Throughput: one transaction per cycle, sustained while the receiver does not stall.
// Pipeline: two front stages, the two restoring dividers of QUO_BITS
// quotient bits each, one quotient bit per stage, where QUO_BITS =
// max(HUE_FRACTION_BITS + 7, CHANNEL_BITS), and the output register.
// Reset clears the valid bits only; the pipeline then holds no transaction.
// When the receiver stalls a full output, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
`default_nettype none
module rgb_to_hls_converter #(
    parameter int CHANNEL_BITS      = rhc_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF,
    localparam int HUE_BITS = $clog2(360 << HUE_FRACTION_BITS),
    localparam int IN_W     = ((3 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,  // red, green, blue
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,  // hue, lightness, saturation
    output logic [0:0]            m_tuser   // achromatic
);
    import rhc_pkg::*;

    localparam int CB       = CHANNEL_BITS;
    localparam int QUO_BITS = (HUE_FRACTION_BITS + 7 > CB) ? HUE_FRACTION_BITS + 7 : CB;
    localparam int NW       = QUO_BITS + CB + 1;
    localparam int LAT      = QUO_BITS + 2;
    localparam logic [HUE_BITS-1:0] HUE_TURN = HUE_BITS'(360 << HUE_FRACTION_BITS);

    typedef struct packed {
        sector_t       sector;
        logic [CB-1:0] light;
        logic          achrom;
    } side_t;

    logic          pipe_en;
    logic          vld_reg [LAT];
    logic [NW-1:0] hue_num, sat_num;
    logic [CB:0]   hue_den, sat_den;
    sector_t       sec_front;
    logic [CB-1:0] light_front;
    logic          achrom_front;
    side_t         side_front;
    side_t         side_reg [QUO_BITS];
    logic [QUO_BITS-1:0] hue_q, sat_q;
    logic [HUE_BITS-1:0] hue;
    logic [CB-1:0]       light, sat;
    logic                achrom;

    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
        end else if (pipe_en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    rhc_front #(
        .CHANNEL_BITS      (CB),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QUO_BITS          (QUO_BITS)
    ) u_front (
        .aclk    (aclk),
        .en      (pipe_en),
        .red     (s_tdata[CB-1:0]),
        .green   (s_tdata[2*CB-1:CB]),
        .blue    (s_tdata[3*CB-1:2*CB]),
        .hue_num (hue_num),
        .hue_den (hue_den),
        .sat_num (sat_num),
        .sat_den (sat_den),
        .sector  (sec_front),
        .light   (light_front),
        .achrom  (achrom_front)
    );

    assign side_front = {sec_front, light_front, achrom_front};

    rhc_div #(.DEN_W(CB + 1), .QUO_W(QUO_BITS)) u_hue_div (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (hue_num),
        .den  (hue_den),
        .quo  (hue_q)
    );

    rhc_div #(.DEN_W(CB + 1), .QUO_W(QUO_BITS)) u_sat_div (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (sat_num),
        .den  (sat_den),
        .quo  (sat_q)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg[0] <= side_front;
            for (int i = 1; i < QUO_BITS; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    rhc_back #(
        .CHANNEL_BITS      (CB),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .QUO_BITS          (QUO_BITS),
        .HUE_BITS          (HUE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (vld_reg[LAT-1]),
        .sector    (side_reg[QUO_BITS-1].sector),
        .hue_q     (hue_q),
        .sat_q     (sat_q),
        .light_in  (side_reg[QUO_BITS-1].light),
        .achrom_in (side_reg[QUO_BITS-1].achrom),
        .out_valid (m_tvalid),
        .hue       (hue),
        .light     (light),
        .sat       (sat),
        .achrom    (achrom)
    );

    assign m_tdata = OUT_W'({sat, light, hue});
    assign m_tuser = achrom;

`include "rgb_to_hls_converter_assert.svh"

    `RHC_ASSERT_IMP(a_gray_zero, aclk, aresetn, m_tvalid && achrom, hue == '0 && sat == '0)
    `RHC_ASSERT_IMP(a_hue_range, aclk, aresetn, m_tvalid, hue < HUE_TURN)
    `RHC_ASSERT_IMP(a_colour_sat, aclk, aresetn, m_tvalid && !achrom, sat != '0)
    `RHC_ASSERT_NXT(a_stall_hold, aclk, aresetn, !pipe_en, $stable(vld_reg[LAT-1]))
endmodule
`default_nettype wire

FILE: tb/sv/rgb_to_hls_checker.sv
// Checker for the RGB to HLS converter: predicts each pixel's HSL and compares results
`default_nettype none
module rgb_to_hls_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [0:0]  m_tuser,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL = 255;
    localparam int TURN = 360 * 64;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  lightness;
        logic [7:0]  saturation;
        logic        achromatic;
    } hsl_t;

    hsl_t hsl_q[$];

    function automatic int round_div(input longint num, input longint den);
        return int'((2 * num + den) / (2 * den));
    endfunction

    function automatic hsl_t pixel_to_hsl(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        hsl_t   res;
        int     mx, mn, d, s, pos, neg, hue;
        rhc_pkg::sector_t sec;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        s = mx + mn;
        d = mx - mn;
        res = '0;
        res.lightness = 8'((s + 1) >> 1);
        if (d == 0) begin
            res.achromatic = 1'b1;
            return res;
        end
        res.saturation = 8'(round_div(longint'(d) * FULL, (s <= FULL) ? s : 2 * FULL - s));
        if (r == mx) begin
            sec = rhc_pkg::SEC_RED; pos = g; neg = b;
        end else if (g == mx) begin
            sec = rhc_pkg::SEC_GREEN; pos = b; neg = r;
        end else begin
            sec = rhc_pkg::SEC_BLUE; pos = r; neg = g;
        end
        hue = round_div(longint'(2 * int'(sec) * d + pos + 6 * d - neg) * 60 * 64, d);
        while (hue >= TURN) hue -= TURN;
        res.hue = 15'(hue);
        return res;
    endfunction

    always @(posedge aclk) begin
        hsl_t exp_r, got;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                hsl_q.push_back(pixel_to_hsl(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[14:0], m_tdata[22:15], m_tdata[30:23], m_tuser[0]};
                if (hsl_q.size() == 0) begin
                    $error("unexpected result transaction %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = hsl_q.pop_front();
                    if (got != exp_r) begin
                        fail_count <= fail_count + 1;
                        if (got.hue != exp_r.hue)
                            $error("hue: expected %0d, got %0d", exp_r.hue, got.hue);
                        if (got.lightness != exp_r.lightness)
                            $error("lightness: expected %0d, got %0d",
                                   exp_r.lightness, got.lightness);
                        if (got.saturation != exp_r.saturation)
                            $error("saturation: expected %0d, got %0d",
                                   exp_r.saturation, got.saturation);
                        if (got.achromatic != exp_r.achromatic)
                            $error("achromatic: expected %0d, got %0d",
                                   exp_r.achromatic, got.achromatic);
                    end
                end
            end
        end
    end

    assign pending = hsl_q.size();
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench top for the RGB to HLS converter: stimulus, back-pressure and verdict
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 400;
    localparam longint LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    int          fail_count, pending;
    int          n_sent = 0, n_gray = 0;
    longint      cycles = 0;
    bit          stim_done = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rgb_to_hls_converter dut (.*);
    rgb_to_hls_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, with stretches of none
    initial begin
        int w;
        bit calm;
        calm = 1'b0;
        forever begin
            calm = ($urandom_range(0, 7) == 0) ? ~calm : calm;
            w = calm ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (r == g && g == b) n_gray++;
    endtask

    function automatic logic [7:0] rnd_chan();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [7:0] r, g, b;
        int gap;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // extremes, greys, every sector, channel ties, negative hue, light/dark saturation
        send_pixel(0, 0, 0, 0);        send_pixel(255, 255, 255, 0);
        send_pixel(128, 128, 128, 0);  send_pixel(255, 0, 0, 0);
        send_pixel(0, 255, 0, 0);      send_pixel(0, 0, 255, 0);
        send_pixel(255, 255, 0, 0);    send_pixel(0, 255, 255, 0);
        send_pixel(255, 0, 255, 0);    send_pixel(200, 10, 100, 0);
        send_pixel(255, 0, 1, 0);      send_pixel(1, 0, 0, 0);
        send_pixel(255, 254, 254, 0);  send_pixel(128, 127, 127, 0);
        send_pixel(127, 128, 128, 0);  send_pixel(10, 20, 30, 0);
        send_pixel(240, 250, 245, 0);  send_pixel(85, 170, 255, 0);
        send_pixel(100, 100, 50, 0);   send_pixel(1, 2, 3, 0);
        // hold off until the pipeline has drained
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        for (int i = 0; i < N_RANDOM; i++) begin
            r = rnd_chan(); g = rnd_chan(); b = rnd_chan();
            if ($urandom_range(0, 15) == 0) begin
                g = r; b = r;
            end
            gap = ((i / 50) % 2) ? 0 : $urandom_range(0, 12);
            send_pixel(r, g, b, gap);
        end
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (40) @(posedge aclk);
        $display("Sent %0d pixels (%0d grey), including all hue sectors, ties and extremes,",
                 n_sent, n_gray);
        $display("with random source gaps and sink stalls on both channels.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_div.sv
rtl/rhc_back.sv
rtl/rgb_to_hls_converter.sv
tb/sv/rgb_to_hls_checker.sv
tb/sv/tb.sv
